>>> design/mva_pkg.sv
// Shared types and constants for the MIDI voice allocator.
package mva_pkg;

  // Most result words one message may give
  localparam logic [5:0] MAX_RESULTS = 6'd32;

  // Message kinds (upper nibble of the status byte)
  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_KEY_PRESS = 4'hA;
  localparam logic [3:0] KIND_CONTROL   = 4'hB;
  localparam logic [3:0] KIND_PROGRAM   = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRES = 4'hD;
  localparam logic [3:0] KIND_BEND      = 4'hE;
  localparam logic [3:0] KIND_SYSTEM    = 4'hF;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_VOICES = 2'd0;
  localparam logic [1:0] CFG_DRUM_MASK     = 2'd1;
  localparam logic [1:0] CFG_VOLUME_CTL    = 2'd2;

  localparam logic [5:0]  ACTIVE_VOICES_RST = 6'd32;
  localparam logic [15:0] DRUM_MASK_RST     = 16'h0200;
  localparam logic [6:0]  VOLUME_CTL_RST    = 7'd7;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_PATCH     = 4'd1,
    ACT_START     = 4'd2,
    ACT_STOP      = 4'd3,
    ACT_VOLUME    = 4'd4,
    ACT_BEND      = 4'd5,
    ACT_KEY_PRESS = 4'd6,
    ACT_CHAN_PRES = 4'd7,
    ACT_END_TRACK = 4'd8,
    ACT_BAD       = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    OP_BAD,
    OP_END,
    OP_NOTE_OFF,
    OP_NOTE_ON,
    OP_PROGRAM,
    OP_FAN_OUT,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PATCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } msg_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  voice;
    logic [7:0]  key_or_patch;
    logic [13:0] amount;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] key;
    logic [3:0] chan;
  } voice_entry_t;

  typedef struct packed {
    logic         en;
    voice_entry_t entry;
  } voice_wr_t;

endpackage

>>> design/mva_voice_ram.sv
// Voice table memory: busy flag, key and channel per voice, with reset valid bits.
module mva_voice_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output mva_pkg::voice_entry_t rd_entry,
  input  mva_pkg::voice_wr_t    wr,
  input  logic [AW-1:0]         wr_addr
);

  mva_pkg::voice_entry_t mem [DEPTH];
  logic [DEPTH-1:0]      vld;
  mva_pkg::voice_entry_t rd_q;
  logic                  rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Never-written voices read as free
  always_comb begin
    rd_entry      = rd_q;
    rd_entry.busy = rd_q.busy & rd_vld;
  end

endmodule

>>> design/mva_prog_ram.sv
// Per-channel program table memory, reading as program 0 until written.
module mva_prog_ram (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] rd_addr,
  output logic [6:0] rd_prog,
  input  logic       wr_en,
  input  logic [3:0] wr_addr,
  input  logic [6:0] wr_prog
);

  logic [6:0]  mem [16];
  logic [15:0] vld;
  logic [6:0]  rd_q;
  logic        rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_prog;
    end
    rd_q   <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_prog = rd_vld ? rd_q : 7'd0;

endmodule

>>> design/midi_voice_allocator.sv
// Top level of the MIDI voice allocator: control sequencer, configuration and memories.
// A message with one fixed result (bad, end track, program change, unknown controller)
// goes from idle straight to the finish state, which registers its word out; a note or
// fan-out message scans up to the n active voices one per cycle through the voice table
// read port. One message is handled at a time; busy falls as the last word goes out.
// Reset: synchronous; all voices free, programs 0, registers to 32 / 0x0200 / 7.
// Result words are strobed for one cycle and cannot be held off by the receiver.
module midi_voice_allocator #(
  parameter int NUM_VOICES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mva_pkg::msg_t    msg,
  output logic             result_valid,
  output mva_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  // Index width of the voice table and width of a counter that can hold the depth
  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  // Configuration registers
  logic [5:0]  active_voices;
  logic [15:0] drum_channel_mask;
  logic [6:0]  volume_controller;

  mva_pkg::state_t state, state_next;
  mva_pkg::msg_t   item;
  mva_pkg::op_t    op;
  mva_pkg::op_t    op_in;

  logic [CW-1:0] rd_idx;
  logic          ev_valid;
  logic [IW-1:0] ev_idx;
  logic [IW-1:0] found_idx;
  logic [5:0]    match_cnt;

  // One result is held back so that the final word of a fan-out can carry last
  mva_pkg::result_t hold;
  logic             hold_vld;

  logic [6:0]    n_ext;
  logic [CW-1:0] n_voices;
  logic          issue;
  logic          scan_end;
  logic          hit_first;
  logic          fan_take;

  mva_pkg::voice_entry_t rd_entry;
  mva_pkg::voice_wr_t    vwr;
  logic [6:0]            prog_rd;
  logic                  prog_we;

  logic             emit;
  mva_pkg::result_t emit_word;
  mva_pkg::result_t fan_word;
  mva_pkg::result_t in_word;
  mva_pkg::result_t stop_word;
  mva_pkg::result_t start_word;
  logic [7:0]       patch;
  logic [3:0]       ch;

  assign ch   = item.status_byte[3:0];
  assign busy = (state != mva_pkg::ST_IDLE);

  // Configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      active_voices     <= mva_pkg::ACTIVE_VOICES_RST;
      drum_channel_mask <= mva_pkg::DRUM_MASK_RST;
      volume_controller <= mva_pkg::VOLUME_CTL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mva_pkg::CFG_ACTIVE_VOICES: active_voices     <= cfg_data[5:0];
        mva_pkg::CFG_DRUM_MASK:     drum_channel_mask <= cfg_data;
        mva_pkg::CFG_VOLUME_CTL:    volume_controller <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Saturate the voice count to the table depth
  always_comb begin
    n_ext = {1'b0, active_voices};
    if (n_ext > 7'(NUM_VOICES)) begin
      n_ext = 7'(NUM_VOICES);
    end
    n_voices = CW'(n_ext);
  end

  // Classify the incoming word
  always_comb begin
    op_in   = mva_pkg::OP_FAN_OUT;
    in_word = '0;
    if (!msg.status_byte[7]) begin
      op_in          = mva_pkg::OP_BAD;
      in_word.action = mva_pkg::ACT_BAD;
    end else begin
      unique case (msg.status_byte[7:4])
        mva_pkg::KIND_SYSTEM: begin
          op_in          = mva_pkg::OP_END;
          in_word.action = mva_pkg::ACT_END_TRACK;
        end
        mva_pkg::KIND_NOTE_OFF: op_in = mva_pkg::OP_NOTE_OFF;
        mva_pkg::KIND_NOTE_ON: begin
          op_in = (msg.second_data == 7'd0) ? mva_pkg::OP_NOTE_OFF : mva_pkg::OP_NOTE_ON;
        end
        mva_pkg::KIND_PROGRAM: op_in = mva_pkg::OP_PROGRAM;
        mva_pkg::KIND_CONTROL: begin
          op_in = (msg.first_data == volume_controller) ? mva_pkg::OP_FAN_OUT
                                                        : mva_pkg::OP_NONE;
        end
        default: op_in = mva_pkg::OP_FAN_OUT;
      endcase
    end
  end

  // Word that a fan-out sends to the voice under evaluation
  always_comb begin
    fan_word        = '0;
    fan_word.voice  = 5'(ev_idx);
    fan_word.amount = {7'd0, item.second_data};
    case (item.status_byte[7:4])
      mva_pkg::KIND_KEY_PRESS: begin
        fan_word.action       = mva_pkg::ACT_KEY_PRESS;
        fan_word.key_or_patch = {1'b0, item.first_data};
      end
      mva_pkg::KIND_CONTROL: fan_word.action = mva_pkg::ACT_VOLUME;
      mva_pkg::KIND_BEND: begin
        fan_word.action = mva_pkg::ACT_BEND;
        fan_word.amount = {item.second_data, item.first_data};
      end
      default: fan_word.action = mva_pkg::ACT_CHAN_PRES;
    endcase
  end

  // Stop word for the matched voice and start word for the allocated one
  always_comb begin
    stop_word               = '0;
    stop_word.action        = mva_pkg::ACT_STOP;
    stop_word.voice         = 5'(ev_idx);
    stop_word.key_or_patch  = {1'b0, item.first_data};
    stop_word.amount        = {7'd0, item.second_data};
    start_word              = '0;
    start_word.action       = mva_pkg::ACT_START;
    start_word.voice        = 5'(found_idx);
    start_word.key_or_patch = {1'b0, item.first_data};
    start_word.amount       = {7'd0, item.second_data};
  end

  // Scan pipeline: issue a read each cycle, evaluate the entry in the cycle after
  assign issue    = (state == mva_pkg::ST_SCAN) && (rd_idx < n_voices);
  assign scan_end = (rd_idx == n_voices) && !ev_valid;

  always_comb begin
    hit_first = 1'b0;
    fan_take  = 1'b0;
    if (ev_valid) begin
      case (op)
        mva_pkg::OP_NOTE_ON: hit_first = !rd_entry.busy;
        mva_pkg::OP_NOTE_OFF: begin
          hit_first = rd_entry.busy && (rd_entry.chan == ch)
                      && (rd_entry.key == item.first_data);
        end
        mva_pkg::OP_FAN_OUT: begin
          fan_take = rd_entry.busy && (rd_entry.chan == ch)
                     && (match_cnt < mva_pkg::MAX_RESULTS)
                     && ((item.status_byte[7:4] != mva_pkg::KIND_KEY_PRESS)
                         || (rd_entry.key == item.first_data));
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mva_pkg::ST_IDLE: begin
        if (start) begin
          if ((op_in == mva_pkg::OP_NOTE_ON) || (op_in == mva_pkg::OP_NOTE_OFF)
              || (op_in == mva_pkg::OP_FAN_OUT)) begin
            state_next = mva_pkg::ST_SCAN;
          end else begin
            state_next = mva_pkg::ST_FINISH;
          end
        end
      end
      mva_pkg::ST_SCAN: begin
        if (hit_first && (op == mva_pkg::OP_NOTE_ON)) begin
          state_next = mva_pkg::ST_PATCH;
        end else if (hit_first || scan_end) begin
          state_next = mva_pkg::ST_FINISH;
        end
      end
      mva_pkg::ST_PATCH:  state_next = mva_pkg::ST_FINISH;
      mva_pkg::ST_FINISH: state_next = mva_pkg::ST_IDLE;
      default:            state_next = mva_pkg::ST_IDLE;
    endcase
  end

  // Drums take note + 128, other channels their stored program
  assign patch = drum_channel_mask[ch] ? {1'b1, item.first_data} : {1'b0, prog_rd};

  // Outputs of the sequencer: result word and memory writes
  always_comb begin
    emit      = 1'b0;
    emit_word = '0;
    vwr       = '0;
    prog_we   = 1'b0;
    unique case (state)
      mva_pkg::ST_IDLE: ;
      mva_pkg::ST_SCAN: begin
        // Release the held word once a further match proves it is not the last
        if (fan_take && hold_vld) begin
          emit      = 1'b1;
          emit_word = hold;
        end
      end
      mva_pkg::ST_PATCH: begin
        emit                   = 1'b1;
        emit_word.action       = mva_pkg::ACT_PATCH;
        emit_word.voice        = 5'(found_idx);
        emit_word.key_or_patch = patch;
        vwr.en                 = 1'b1;
        vwr.entry.busy         = 1'b1;
        vwr.entry.key          = item.first_data;
        vwr.entry.chan         = ch;
      end
      mva_pkg::ST_FINISH: begin
        emit = 1'b1;
        if (hold_vld) begin
          emit_word = hold;
        end
        emit_word.last = 1'b1;
        if ((op == mva_pkg::OP_NOTE_OFF) && hold_vld) begin
          vwr.en         = 1'b1;
          vwr.entry.busy = 1'b0;
          vwr.entry.key  = item.first_data;
          vwr.entry.chan = ch;
        end
        prog_we = (op == mva_pkg::OP_PROGRAM);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mva_pkg::ST_IDLE;
      ev_valid     <= 1'b0;
      hold_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      ev_valid     <= issue;
      result_valid <= emit;
      if ((state == mva_pkg::ST_IDLE) && start) begin
        hold_vld <= (op_in == mva_pkg::OP_BAD) || (op_in == mva_pkg::OP_END);
      end else if (fan_take || hit_first && (op == mva_pkg::OP_NOTE_OFF)
                   || (state == mva_pkg::ST_PATCH)) begin
        hold_vld <= 1'b1;
      end
    end
  end

  // Payload and counters
  always_ff @(posedge clk) begin
    result <= emit_word;
    ev_idx <= rd_idx[IW-1:0];
    if (issue) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if ((state == mva_pkg::ST_IDLE) && start) begin
      item      <= msg;
      op        <= op_in;
      hold      <= in_word;
      rd_idx    <= '0;
      match_cnt <= '0;
    end
    if (fan_take) begin
      hold      <= fan_word;
      match_cnt <= match_cnt + 6'd1;
    end
    if (hit_first) begin
      found_idx <= ev_idx;
      if (op == mva_pkg::OP_NOTE_OFF) begin
        hold <= stop_word;
      end
    end
    if (state == mva_pkg::ST_PATCH) begin
      hold <= start_word;
    end
  end

  mva_voice_ram #(
    .DEPTH (NUM_VOICES),
    .AW    (IW)
  ) u_voice_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue),
    .rd_addr  (rd_idx[IW-1:0]),
    .rd_entry (rd_entry),
    .wr       (vwr),
    .wr_addr  (found_idx)
  );

  mva_prog_ram u_prog_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (ch),
    .rd_prog (prog_rd),
    .wr_en   (prog_we),
    .wr_addr (ch),
    .wr_prog (item.first_data)
  );

endmodule

>>> design/mva_checker.sv
// Port-level checks for the MIDI voice allocator, bound to the top level.
module mva_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input mva_pkg::result_t result
);

  // A message accepted keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted message did not raise busy");

  // The last word of a message is never followed at once by another word
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("word directly after the last word of a message");

  // A patch word is followed by the start word that closes the note-on
  a_patch_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.action == mva_pkg::ACT_PATCH)) |=>
      (result_valid && (result.action == mva_pkg::ACT_START) && result.last
       && (result.voice == $past(result.voice))))
    else $error("patch word not followed by start on the same voice");

  // Results appear only while a message is in hand or just finishing
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || busy))
    else $error("result word without a message in progress");

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
